>>> design/ffira_pkg.sv
// Shared constants, types and a helper function of the first-fit interval room allocator.
`default_nettype none

package ffira_pkg;

    localparam int MAX_ROOMS_DEF      = 16;
    localparam int SLOTS_PER_ROOM_DEF = 16;
    localparam int TIME_BITS_DEF      = 16;

    // Fixed widths of the transaction fields.
    localparam int IN_TIME_W  = 16;
    localparam int ROOM_IDX_W = 4;
    localparam int ROOM_CNT_W = 5;

    localparam logic STATUS_PLACED  = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    function automatic int clog2_min1(input int value);
        int bits;
        bits = $clog2(value);
        return (bits < 1) ? 1 : bits;
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic cnt_rd;
        logic scan_start;
        logic issue;
        logic next_room;
        logic place_old;
        logic place_new;
        logic drop;
    } ffira_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic room_lt_open;
        logic can_open;
        logic cnt_full;
        logic issue_done;
        logic hit;
        logic out_free;
    } ffira_status_t;

endpackage

`default_nettype wire

>>> design/ffira_req_if.sv
// Request channel interface: valid/ready handshake with the interval payload.
`default_nettype none

interface ffira_req_if;
    import ffira_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 first_of_set;
    logic [IN_TIME_W-1:0] start_time;
    logic [IN_TIME_W-1:0] end_time;

    modport source (output valid, output first_of_set, output start_time, output end_time,
                    input ready);
    modport sink   (input valid, input first_of_set, input start_time, input end_time,
                    output ready);
endinterface

`default_nettype wire

>>> design/ffira_rsp_if.sv
// Response channel interface: valid/ready handshake with the placement result.
`default_nettype none

interface ffira_rsp_if;
    import ffira_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ROOM_IDX_W-1:0] room_index;
    logic [ROOM_CNT_W-1:0] rooms_in_use;
    logic                  status;

    modport source (output valid, output room_index, output rooms_in_use, output status,
                    input ready);
    modport sink   (input valid, input room_index, input rooms_in_use, input status,
                    output ready);
endinterface

`default_nettype wire

>>> design/ffira_ctrl.sv
// Controller state machine that sequences the room and booking scan.
`default_nettype none

module ffira_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_valid,
    output logic                          req_ready,
    input  wire ffira_pkg::ffira_status_t status_in,
    output ffira_pkg::ffira_cmd_t         cmd
);
    import ffira_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROOM  = 4'b0010,
        ST_COUNT = 4'b0100,
        ST_SCAN  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        req_ready  = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ROOM;
                end
            end
            ST_ROOM:
            begin
                if (status_in.room_lt_open)
                begin
                    cmd.cnt_rd = 1'b1;
                    state_next = ST_COUNT;
                end
                else if (status_in.out_free)
                begin
                    // No open room fits: open the next one, or drop when none is left.
                    if (status_in.can_open)
                        cmd.place_new = 1'b1;
                    else
                        cmd.drop = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_COUNT:
            begin
                if (status_in.cnt_full)
                begin
                    cmd.next_room = 1'b1;
                    state_next    = ST_ROOM;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status_in.hit)
                begin
                    cmd.next_room = 1'b1;
                    state_next    = ST_ROOM;
                end
                else if (!status_in.issue_done)
                begin
                    cmd.issue = 1'b1;
                end
                else if (status_in.out_free)
                begin
                    cmd.place_old = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

>>> design/ffira_dp.sv
// Datapath: booking memory, per-room counts, scan counters and the result register.
`default_nettype none

module ffira_dp #(
    parameter int MAX_ROOMS      = ffira_pkg::MAX_ROOMS_DEF,
    parameter int SLOTS_PER_ROOM = ffira_pkg::SLOTS_PER_ROOM_DEF,
    parameter int TIME_BITS      = ffira_pkg::TIME_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ffira_pkg::ffira_cmd_t          cmd,
    output ffira_pkg::ffira_status_t            status_out,
    input  wire logic                           first_of_set,
    input  wire logic [ffira_pkg::IN_TIME_W-1:0] start_time,
    input  wire logic [ffira_pkg::IN_TIME_W-1:0] end_time,
    ffira_rsp_if.source                         rsp
);
    import ffira_pkg::*;

    localparam int SLOT_TOTAL = MAX_ROOMS * SLOTS_PER_ROOM;
    localparam int ADDR_W     = clog2_min1(SLOT_TOTAL);
    localparam int ROOM_W     = clog2_min1(MAX_ROOMS);
    localparam int CNT_W      = clog2_min1(MAX_ROOMS + 1);
    localparam int SLOT_CNT_W = clog2_min1(SLOTS_PER_ROOM + 1);

    // Each entry holds {begin, finish} of one booking.
    logic [2*TIME_BITS-1:0]  book_mem [SLOT_TOTAL];
    logic [SLOT_CNT_W-1:0]   cnt_mem  [MAX_ROOMS];

    logic [TIME_BITS-1:0]    s_reg, s_next;
    logic [TIME_BITS-1:0]    e_reg, e_next;
    logic [CNT_W-1:0]        open_reg, open_next;
    logic [CNT_W-1:0]        room_reg, room_next;
    logic [ADDR_W-1:0]       base_reg, base_next;
    logic [SLOT_CNT_W-1:0]   k_reg, k_next;
    logic                    rd_valid_reg;
    logic [SLOT_CNT_W-1:0]   cnt_q_reg;
    logic [2*TIME_BITS-1:0]  book_q_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [ROOM_IDX_W-1:0]   out_room_reg, out_room_next;
    logic [ROOM_CNT_W-1:0]   out_rooms_reg, out_rooms_next;
    logic                    out_status_reg, out_status_next;

    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ADDR_W-1:0]       rd_addr;
    logic [SLOT_CNT_W-1:0]   wr_cnt;
    logic [ROOM_W-1:0]       room_idx;
    logic [TIME_BITS-1:0]    q_begin;
    logic [TIME_BITS-1:0]    q_finish;
    logic                    placing;

    assign room_idx = room_reg[ROOM_W-1:0];
    assign q_begin  = book_q_reg[2*TIME_BITS-1:TIME_BITS];
    assign q_finish = book_q_reg[TIME_BITS-1:0];
    assign placing  = cmd.place_old | cmd.place_new;

    assign wr_en   = placing;
    assign wr_addr = cmd.place_new ? base_reg : base_reg + ADDR_W'(cnt_q_reg);
    assign wr_cnt  = cmd.place_new ? SLOT_CNT_W'(1) : cnt_q_reg + SLOT_CNT_W'(1);
    assign rd_addr = base_reg + ADDR_W'(k_reg);

    always_comb
    begin
        status_out.room_lt_open = (room_reg < open_reg);
        status_out.can_open     = (open_reg < CNT_W'(MAX_ROOMS));
        status_out.cnt_full     = (cnt_q_reg >= SLOT_CNT_W'(SLOTS_PER_ROOM));
        status_out.issue_done   = (k_reg == cnt_q_reg);
        // Half-open intervals overlap when each starts before the other ends.
        status_out.hit          = rd_valid_reg && (s_reg < q_finish) && (q_begin < e_reg);
        status_out.out_free     = !out_valid_reg || rsp.ready;
    end

    always_comb
    begin
        s_next    = s_reg;
        e_next    = e_reg;
        open_next = open_reg;
        room_next = room_reg;
        base_next = base_reg;
        k_next    = k_reg;
        if (cmd.load)
        begin
            s_next    = TIME_BITS'(start_time);
            e_next    = TIME_BITS'(end_time);
            room_next = '0;
            base_next = '0;
            if (first_of_set)
                open_next = '0;
        end
        if (cmd.next_room)
        begin
            room_next = room_reg + CNT_W'(1);
            base_next = base_reg + ADDR_W'(SLOTS_PER_ROOM);
        end
        if (cmd.scan_start)
            k_next = '0;
        if (cmd.issue)
            k_next = k_reg + SLOT_CNT_W'(1);
        if (cmd.place_new)
            open_next = open_reg + CNT_W'(1);
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_room_next   = out_room_reg;
        out_rooms_next  = out_rooms_reg;
        out_status_next = out_status_reg;
        if (placing)
        begin
            out_valid_next  = 1'b1;
            out_room_next   = ROOM_IDX_W'(room_reg);
            out_rooms_next  = ROOM_CNT_W'(open_next);
            out_status_next = STATUS_PLACED;
        end
        else if (cmd.drop)
        begin
            out_valid_next  = 1'b1;
            out_room_next   = '0;
            out_rooms_next  = ROOM_CNT_W'(open_reg);
            out_status_next = STATUS_DROPPED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= '0;
            room_reg      <= '0;
            base_reg      <= '0;
            k_reg         <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            open_reg      <= open_next;
            room_reg      <= room_next;
            base_reg      <= base_next;
            k_reg         <= k_next;
            rd_valid_reg  <= cmd.issue;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg          <= s_next;
        e_reg          <= e_next;
        out_room_reg   <= out_room_next;
        out_rooms_reg  <= out_rooms_next;
        out_status_reg <= out_status_next;
    end

    // Booking memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            book_mem[wr_addr] <= {s_reg, e_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
            book_q_reg <= book_mem[rd_addr];
    end

    // A room's count is written when the room opens, so it needs no reset.
    always_ff @(posedge clk)
    begin
        if (placing)
            cnt_mem[room_idx] <= wr_cnt;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cnt_rd)
            cnt_q_reg <= cnt_mem[room_idx];
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.room_index   = out_room_reg;
    assign rsp.rooms_in_use = out_rooms_reg;
    assign rsp.status       = out_status_reg;

endmodule

`default_nettype wire

>>> design/first_fit_interval_room_allocator.sv
// Top level of the first-fit interval room allocator.
// Per room visited in order, the scan moves on at a full room or at its first overlap;
// the request goes into the first room it fits, else opens a new room, or is dropped when
// none is left. Each result waits for the output register to be free. A new transaction is
// taken only after the last is placed or dropped, also while that result waits in the output.
// Reset clears the open room count, the output valid and all control state, not the bookings.
`default_nettype none

module first_fit_interval_room_allocator #(
    parameter int MAX_ROOMS      = ffira_pkg::MAX_ROOMS_DEF,
    parameter int SLOTS_PER_ROOM = ffira_pkg::SLOTS_PER_ROOM_DEF,
    parameter int TIME_BITS      = ffira_pkg::TIME_BITS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ffira_req_if.sink    req,
    ffira_rsp_if.source  rsp
);
    import ffira_pkg::*;

    ffira_cmd_t    cmd;
    ffira_status_t status;
    logic          req_ready;

    assign req.ready = req_ready;

    ffira_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .status_in (status),
        .cmd       (cmd)
    );

    ffira_dp #(
        .MAX_ROOMS      (MAX_ROOMS),
        .SLOTS_PER_ROOM (SLOTS_PER_ROOM),
        .TIME_BITS      (TIME_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status_out   (status),
        .first_of_set (req.first_of_set),
        .start_time   (req.start_time),
        .end_time     (req.end_time),
        .rsp          (rsp)
    );

endmodule

`default_nettype wire
